>>> rtl/itr_pkg.sv
package itr_pkg;

  localparam int unsigned NumW    = 12;
  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned MultW   = 14;
  localparam int unsigned PosW    = 2;
  localparam int unsigned SymIdxW = 2;

  localparam logic [NumW-1:0] Limit = NumW'(4000);

  // Decimal place being converted, most significant first
  localparam logic [PosW-1:0] PosThousands = 2'd0;
  localparam logic [PosW-1:0] PosHundreds  = 2'd1;
  localparam logic [PosW-1:0] PosTens      = 2'd2;
  localparam logic [PosW-1:0] PosUnits     = 2'd3;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_e;

  typedef struct packed {
    logic load;       // take a new number
    logic extract;    // split off the digit of the current place
    logic push_char;  // write the current letter to the output register
    logic push_flag;  // write the out-of-range or empty result
    logic next_sym;   // advance to the next letter of this digit
    logic next_pos;   // advance to the next lower place
  } itr_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic is_over;
    logic digit_zero;
    logic sym_last;
    logic run_last;
    logic slot_free;
  } itr_sts_t;

  function automatic logic [MultW-1:0] place_mult(logic [PosW-1:0] pos,
                                                  logic [DigitW-1:0] k);
    logic [MultW-1:0] place;
    unique case (pos)
      PosThousands: place = MultW'(1000);
      PosHundreds:  place = MultW'(100);
      PosTens:      place = MultW'(10);
      PosUnits:     place = MultW'(1);
      default:      place = MultW'(1);
    endcase
    return MultW'(place * MultW'(k));
  endfunction

  // Number of letters of one decimal digit
  function automatic logic [SymIdxW:0] pat_len(logic [DigitW-1:0] d);
    logic [SymIdxW:0] len;
    unique case (d)
      4'd1, 4'd5:       len = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             len = 3'd2;
      4'd3, 4'd7:       len = 3'd3;
      4'd8:             len = 3'd4;
      default:          len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic sym_e pat_sym(logic [DigitW-1:0] d, logic [SymIdxW-1:0] idx);
    sym_e s;
    if (d == 4'd9) begin
      s = (idx == '0) ? SYM_ONE : SYM_TEN;
    end else if (d == 4'd4) begin
      s = (idx == '0) ? SYM_ONE : SYM_FIVE;
    end else if (d >= 4'd5) begin
      s = (idx == '0) ? SYM_FIVE : SYM_ONE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  function automatic logic [CharW-1:0] letter(logic [PosW-1:0] pos, sym_e s);
    logic [CharW-1:0] c;
    c = "I";
    unique case (pos)
      PosThousands: c = "M";
      PosHundreds: begin
        unique case (s)
          SYM_ONE:  c = "C";
          SYM_FIVE: c = "D";
          default:  c = "M";
        endcase
      end
      PosTens: begin
        unique case (s)
          SYM_ONE:  c = "X";
          SYM_FIVE: c = "L";
          default:  c = "C";
        endcase
      end
      default: begin
        unique case (s)
          SYM_ONE:  c = "I";
          SYM_FIVE: c = "V";
          default:  c = "X";
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/itr_ctrl.sv
module itr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  itr_pkg::itr_sts_t sts_i,
  output itr_pkg::itr_cmd_t cmd_o
);
  import itr_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDigit = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.is_zero || sts_i.is_over) begin
          if (sts_i.slot_free) begin
            cmd_o.push_flag = 1'b1;
            state_d         = StIdle;
          end
        end else begin
          state_d = StDigit;
        end
      end
      StDigit: begin
        cmd_o.extract = 1'b1;
        // skip a zero digit, it has no letters
        if (sts_i.digit_zero) begin
          cmd_o.next_pos = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      default: begin
        if (sts_i.slot_free) begin
          cmd_o.push_char = 1'b1;
          if (sts_i.run_last) begin
            state_d = StIdle;
          end else if (sts_i.sym_last) begin
            cmd_o.next_pos = 1'b1;
            state_d        = StDigit;
          end else begin
            cmd_o.next_sym = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/itr_dpath.sv
module itr_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  itr_pkg::itr_cmd_t           cmd_i,
  output itr_pkg::itr_sts_t           sts_o,
  input  logic [itr_pkg::NumW-1:0]    number_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [itr_pkg::CharW-1:0]   roman_char_o,
  output logic                        last_o,
  output logic                        out_of_range_o,
  output logic                        empty_res_o
);
  import itr_pkg::*;

  logic [NumW-1:0]    rem_q;
  logic [PosW-1:0]    pos_q;
  logic [DigitW-1:0]  digit_q;
  logic [SymIdxW-1:0] idx_q;

  logic               out_valid_q;
  logic [CharW-1:0]   char_q;
  logic               last_q, ovr_q, emp_q;

  logic [DigitW-1:0]  digit_d;
  logic [MultW-1:0]   sub_val;
  logic [SymIdxW:0]   len;
  logic               slot_free;

  // Digit of the current place: highest multiple not above the remainder
  always_comb begin
    digit_d = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({(MultW-NumW)'(0), rem_q} >= place_mult(pos_q, DigitW'(k))) begin
        digit_d = DigitW'(k);
      end
    end
    sub_val = place_mult(pos_q, digit_d);
  end

  assign len       = pat_len(digit_q);
  assign slot_free = !out_valid_q || out_ready_i;

  assign sts_o.is_zero    = (rem_q == '0);
  assign sts_o.is_over    = (rem_q >= Limit);
  assign sts_o.digit_zero = (digit_d == '0);
  assign sts_o.sym_last   = ({1'b0, idx_q} == len - 1'b1);
  assign sts_o.run_last   = sts_o.sym_last && ((pos_q == PosUnits) || (rem_q == '0));
  assign sts_o.slot_free  = slot_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= number_i;
      pos_q <= PosThousands;
    end else begin
      if (cmd_i.extract) begin
        rem_q   <= NumW'({(MultW-NumW)'(0), rem_q} - sub_val);
        digit_q <= digit_d;
        idx_q   <= '0;
      end
      if (cmd_i.next_pos) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.next_sym) begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (cmd_i.push_char) begin
      char_q <= letter(pos_q, pat_sym(digit_q, idx_q));
      last_q <= sts_o.run_last;
      ovr_q  <= 1'b0;
      emp_q  <= 1'b0;
    end else if (cmd_i.push_flag) begin
      char_q <= '0;
      last_q <= 1'b1;
      ovr_q  <= sts_o.is_over;
      emp_q  <= sts_o.is_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_char || cmd_i.push_flag) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign roman_char_o   = char_q;
  assign last_o         = last_q;
  assign out_of_range_o = ovr_q;
  assign empty_res_o    = emp_q;

endmodule

>>> rtl/integer_to_roman_numeral_unit.sv
// Integer to Roman numeral unit. Each number taken on the slave stream comes
// out on the master stream as its Roman numeral, one ASCII letter per item,
// thousands first, with tlast on the final letter. A number of 4000 or more
// gives a single item with tuser bit 0 (out of range) set, zero gives a single
// item with tuser bit 1 (empty) set; both carry tdata zero and tlast high.
// Numbers are converted one at a time: the slave side is ready only while the
// sequencer is idle. A number takes a load step, a check step, a digit step
// per decimal place from thousands down to its last nonzero digit, and an
// emit step per letter, so 3888 takes the most steps. Letters leave through
// the single output register, which the master may stall. The output register
// lets the next number load while the last letter of the previous one still
// waits on the master side.
module integer_to_roman_numeral_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] number, [15:12] unused
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] roman_char
  output logic        m_axis_tlast,   // last letter of the numeral
  output logic [1:0]  m_axis_tuser    // [0] out_of_range, [1] empty_res
);
  import itr_pkg::*;

  itr_cmd_t cmd;
  itr_sts_t sts;

  // Sequence load, digit split and letter emission
  itr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold remainder, current digit and the output register
  itr_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .number_i       (s_axis_tdata[NumW-1:0]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .roman_char_o   (m_axis_tdata),
    .last_o         (m_axis_tlast),
    .out_of_range_o (m_axis_tuser[0]),
    .empty_res_o    (m_axis_tuser[1])
  );

endmodule

>>> dv/roman_numeral_checker.sv
`timescale 1ns / 100ps

// Watch both streams of the Roman numeral unit, expand every accepted number
// into the letters it must produce, and compare each delivered letter with
// the oldest letter still owed.
module roman_numeral_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        num_valid_i,
  input  logic        num_ready_i,
  input  logic [15:0] num_data_i,     // [11:0] number, [15:12] unused
  input  logic        let_valid_i,
  input  logic        let_ready_i,
  input  logic [7:0]  let_data_i,     // [7:0] roman_char
  input  logic        let_last_i,
  input  logic [1:0]  let_user_i,     // [0] out_of_range, [1] empty_res
  output int unsigned err_count_o,
  output int unsigned letters_due_o
);
  import itr_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] glyph;
    logic             last;
    logic             over;
    logic             empty;
  } numeral_letter_t;

  numeral_letter_t letters_owed_q[$];

  function automatic void add_letter(logic [CharW-1:0] ch);
    numeral_letter_t item;
    item.glyph = ch;
    item.last  = 1'b0;
    item.over  = 1'b0;
    item.empty = 1'b0;
    letters_owed_q.push_back(item);
  endfunction

  // One decimal digit in the subtractive notation of its place
  function automatic void add_digit(int unsigned d, logic [CharW-1:0] one,
                                    logic [CharW-1:0] five, logic [CharW-1:0] ten);
    int unsigned ones;
    if (d == 9) begin
      add_letter(one);
      add_letter(ten);
    end else if (d == 4) begin
      add_letter(one);
      add_letter(five);
    end else begin
      ones = d;
      if (d >= 5) begin
        add_letter(five);
        ones = d - 5;
      end
      repeat (ones) add_letter(one);
    end
  endfunction

  function automatic void expand_numeral(logic [NumW-1:0] number);
    int unsigned     v;
    numeral_letter_t item;
    v = number;
    if (v >= Limit || v == 0) begin
      // single flag item, no letter
      item.glyph = '0;
      item.last  = 1'b1;
      item.over  = (v >= Limit);
      item.empty = (v == 0);
      letters_owed_q.push_back(item);
    end else begin
      add_digit(v / 1000, "M", "M", "M");
      add_digit((v % 1000) / 100, "C", "D", "M");
      add_digit((v % 100) / 10, "X", "L", "C");
      add_digit(v % 10, "I", "V", "X");
      // mark the closing letter of the run
      item = letters_owed_q.pop_back();
      item.last = 1'b1;
      letters_owed_q.push_back(item);
    end
  endfunction

  always @(posedge clk_i) begin
    numeral_letter_t want;
    if (!rst_ni) begin
      err_count_o = 0;
    end else begin
      if (num_valid_i && num_ready_i) begin
        expand_numeral(num_data_i[NumW-1:0]);
      end
      if (let_valid_i && let_ready_i) begin
        if (letters_owed_q.size() == 0) begin
          err_count_o = err_count_o + 1;
          $display("%0t: unexpected item: char %02h last %b user %b", $time,
                   let_data_i, let_last_i, let_user_i);
        end else begin
          want = letters_owed_q.pop_front();
          if (let_data_i !== want.glyph || let_last_i !== want.last ||
              let_user_i[0] !== want.over || let_user_i[1] !== want.empty) begin
            err_count_o = err_count_o + 1;
            $display("%0t: want char %02h last %b ovr %b emp %b, got %02h %b %b %b",
                     $time, want.glyph, want.last, want.over, want.empty,
                     let_data_i, let_last_i, let_user_i[0], let_user_i[1]);
          end
        end
      end
    end
    letters_due_o <= letters_owed_q.size();
  end

endmodule

>>> dv/integer_to_roman_numeral_unit_tb.sv
`timescale 1ns / 100ps

// Drive numbers into the Roman numeral unit and pull letters out of it, with
// random idling on both sides; the checker beside the block does the scoring.
module integer_to_roman_numeral_unit_tb;
  import itr_pkg::*;

  // Worst case: every number 15 letters, each letter behind a long stall
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 40;

  typedef enum int unsigned {
    RX_RANDOM,
    RX_STEADY,
    RX_HOLDOFF
  } rx_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata  = '0;    // [11:0] number, [15:12] unused
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;          // [7:0] roman_char
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;          // [0] out_of_range, [1] empty_res

  int unsigned errors;
  int unsigned letters_due;
  int unsigned cycle_count = 0;
  rx_mode_e    rx_mode     = RX_RANDOM;
  bit          tx_gaps     = 1'b1;

  // Corner numbers: flags, every subtractive pattern, the longest numeral,
  // the range edges, and junk in the unused upper bits
  logic [15:0] corner_words [0:24] = '{
    16'd0,    16'd1,    16'd2,    16'd3,    16'd4,
    16'd5,    16'd8,    16'd9,    16'd10,   16'd40,
    16'd49,   16'd90,   16'd400,  16'd444,  16'd500,
    16'd900,  16'd999,  16'd1000, 16'd1994, 16'd3000,
    16'd3888, 16'd3999, 16'd4000, 16'd4095, 16'hF007
  };

  always #1 clk_i = ~clk_i;

  integer_to_roman_numeral_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  roman_numeral_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_valid_i   (s_axis_tvalid),
    .num_ready_i   (s_axis_tready),
    .num_data_i    (s_axis_tdata),
    .let_valid_i   (m_axis_tvalid),
    .let_ready_i   (m_axis_tready),
    .let_data_i    (m_axis_tdata),
    .let_last_i    (m_axis_tlast),
    .let_user_i    (m_axis_tuser),
    .err_count_o   (errors),
    .letters_due_o (letters_due)
  );

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Favor real numerals, small ones included, with flags and raw values mixed in
  function automatic logic [15:0] random_word();
    logic [NumW-1:0] number;
    int unsigned     roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) number = '0;
    else if (roll < 18) number = NumW'($urandom_range(4000, 4095));
    else if (roll < 30) number = NumW'($urandom_range(0, 4095));
    else if (roll < 50) number = NumW'($urandom_range(1, 99));
    else number = NumW'($urandom_range(1, 3999));
    return {4'($urandom), number};
  endfunction

  // Hold the number until the block takes it, then maybe idle a while
  task automatic offer_number(input logic [15:0] word);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed letter has come out
  task automatic wait_for_letters();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (letters_due != 0);
  endtask

  // Receiver: random stalls, steady acceptance, or one long hold-off
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_mode == RX_HOLDOFF && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (rx_mode == RX_STEADY) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("integer_to_roman_numeral_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner numbers back to back
    tx_gaps = 1'b0;
    for (k = 0; k < 25; k++) offer_number(corner_words[k]);
    wait_for_letters();

    // random numbers with idling on both sides
    tx_gaps = 1'b1;
    for (k = 0; k < 150; k++) offer_number(random_word());

    // hold the receiver off while the sender keeps pushing, so the block backs up
    rx_mode <= RX_HOLDOFF;
    tx_gaps = 1'b0;
    for (k = 0; k < 40; k++) offer_number(random_word());
    wait_for_letters();

    // a stretch with no idling anywhere
    rx_mode <= RX_STEADY;
    for (k = 0; k < 150; k++) offer_number(random_word());

    rx_mode <= RX_RANDOM;
    tx_gaps = 1'b1;
    for (k = 0; k < 160; k++) offer_number(random_word());
    wait_for_letters();
    repeat (SettleCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("integer_to_roman_numeral_unit: match");
    end else begin
      $display("integer_to_roman_numeral_unit: mismatch");
    end
    $finish;
  end

endmodule
